// ===== rtl/rksd_pkg.sv =====
// Shared types and constants for the status keystream decrypt unit.
// Holds the controller/datapath command and status structs and cipher constants.
// No dependencies.
package rksd_pkg;

  // Number of keystream bytes held in the cache (three extraction rounds).
  localparam int KS_BYTES = 48;
  localparam int KS_AW    = 6;

  // Subtypes that carry an encrypted status byte.
  localparam logic [7:0] SUBTYPE_A = 8'h7a;
  localparam logic [7:0] SUBTYPE_B = 8'h74;
  localparam logic [7:0] SUBTYPE_C = 8'h79;

  // Seed values that mean the device key is unknown.
  localparam logic [15:0] SEED_NONE_LO = 16'h0000;
  localparam logic [15:0] SEED_NONE_HI = 16'hffff;

  // First counter value that is reported as not valid.
  localparam logic [15:0] CNT_LIMIT = 16'd65532;

  // Reciprocal of 12 for the counter group: q = (cnt * RECIP12) >> RECIP_SH.
  localparam logic [15:0] RECIP12  = 16'd43691;
  localparam int          RECIP_SH = 19;

  // Cached group value after reset (0xffff / 12).
  localparam logic [12:0] GRP_RESET = 13'd5461;

  // Key schedule start point: i = 24, i mod 7 = 3, step 12.
  localparam logic [16:0] KEY_I0   = 17'd24;
  localparam logic [2:0]  KEY_M0   = 3'd3;
  localparam logic [16:0] KEY_STEP = 17'd12;

  // Check nibble adjust and status mask.
  localparam logic [3:0] CHK_XOR     = 4'h1;
  localparam logic [7:0] STATUS_MASK = 8'hfc;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_frame;
    logic       div;
    logic       key_init;
    logic       key_step;
    logic       setup;
    logic       ctr_step;
    logic       mul;
    logic       gv;
    logic       xs_upd;
    logic       reinit;
    logic       ks_wr;
    logic       cache_mark;
    logic       rd;
    logic       out_load;
    logic [2:0] idx;
    logic [1:0] ext_rnd;
    logic [3:0] ext_byte;
  } rksd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eligible;
    logic need_gen;
    logic key_last;
  } rksd_sts_t;

  // Counter-system increments for each state word.
  function automatic logic [31:0] ctr_add(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0, 3'd3, 3'd6: v = 32'h4D34D34D;
      3'd1, 3'd4, 3'd7: v = 32'hD34D34D3;
      default:          v = 32'h34D34D34;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rksd_datapath.sv =====
// Datapath: seed register, key schedule, cipher state, shared squarer,
// keystream cache memory and the output word register. Depends on rksd_pkg.
module rksd_datapath import rksd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [7:0]  in_frame_subtype,
  input  logic [15:0] in_frame_counter,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_check_byte,
  input  rksd_cmd_t   cmd,
  output rksd_sts_t   sts,
  output logic        out_flags_valid,
  output logic [7:0]  out_status_out,
  output logic        out_loop_one,
  output logic        out_tamper,
  output logic        out_loop_two,
  output logic        out_alarm,
  output logic        out_low_batt,
  output logic        out_heartbeat
);

  logic [15:0] seed_r;
  logic        cache_valid_r;
  logic [12:0] cached_grp_r;

  logic [7:0]  sub_r;
  logic [15:0] cnt_r;
  logic [7:0]  stat_r;
  logic [7:0]  chk_r;
  logic [12:0] grp_r;

  logic [15:0] kw_r [8];
  logic [16:0] i_r;
  logic [2:0]  m_r;

  logic [31:0] xs_r [8];
  logic [31:0] cs_r [8];
  logic [31:0] gv_r [8];
  logic        carry_r;
  logic [63:0] prod_r;

  logic [7:0]  ks_mem [KS_BYTES];
  logic [7:0]  rd0_r;
  logic [7:0]  rd2_r;

  logic        fv_r;
  logic [7:0]  so_r;
  logic [5:0]  bits_r;

  logic [31:0] div_prod;
  logic [15:0] grp_x12;
  logic [3:0]  mod12;
  logic [KS_AW-1:0] addr0;
  logic [KS_AW-1:0] addr2;
  logic [KS_AW-1:0] wr_addr;
  logic [32:0] ctr_sum;
  logic [31:0] sq_in;
  logic [31:0] xs_new [8];
  logic [2:0]  wn;
  logic [15:0] wword;
  logic [7:0]  wbyte;
  logic        match;
  logic [7:0]  dec;

  // Seed register and cache bookkeeping; any seed write drops the cache.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r        <= SEED_NONE_HI;
      cache_valid_r <= 1'b0;
      cached_grp_r  <= GRP_RESET;
    end else if (cfg_wr_en) begin
      seed_r        <= cfg_wr_data;
      cache_valid_r <= 1'b0;
    end else if (cmd.cache_mark) begin
      cache_valid_r <= 1'b1;
      cached_grp_r  <= grp_r;
    end
  end

  // Frame capture and counter group by reciprocal multiply.
  assign div_prod = {16'b0, cnt_r} * {16'b0, RECIP12};

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      sub_r  <= in_frame_subtype;
      cnt_r  <= in_frame_counter;
      stat_r <= in_status_byte;
      chk_r  <= in_check_byte;
    end
    if (cmd.div) begin
      grp_r <= div_prod[RECIP_SH +: 13];
    end
  end

  // Counter position inside its group and the two cache addresses.
  assign grp_x12 = {grp_r, 3'b000} + {1'b0, grp_r, 2'b00};
  assign mod12   = 4'(cnt_r - grp_x12);
  assign addr0   = {mod12, 2'b00};
  assign addr2   = {mod12, 2'b10};
  assign wr_addr = {cmd.ext_rnd, cmd.ext_byte};

  assign sts.eligible = ((sub_r == SUBTYPE_A) || (sub_r == SUBTYPE_B) ||
                         (sub_r == SUBTYPE_C)) &&
                        (seed_r != SEED_NONE_LO) && (seed_r != SEED_NONE_HI) &&
                        (cnt_r < CNT_LIMIT);
  assign sts.need_gen = !cache_valid_r || (grp_r != cached_grp_r);
  assign sts.key_last = (i_r + KEY_STEP) > {1'b0, cnt_r};

  // Key word schedule: one mixing step per cycle.
  always_ff @(posedge clk) begin
    if (cmd.key_init) begin
      kw_r[0] <= seed_r;
      kw_r[1] <= seed_r + 16'h0025;
      kw_r[2] <= seed_r - 16'h0004;
      kw_r[3] <= seed_r + 16'h002c;
      kw_r[4] <= seed_r - 16'h0009;
      kw_r[5] <= seed_r - 16'h001d;
      kw_r[6] <= seed_r ^ 16'h00f9;
      kw_r[7] <= seed_r ^ 16'h0022;
      i_r     <= KEY_I0;
      m_r     <= KEY_M0;
    end else if (cmd.key_step) begin
      kw_r[m_r] <= kw_r[m_r] + i_r[15:0] + {13'b0, m_r};
      kw_r[7]   <= kw_r[7] ^ {13'b0, m_r};
      i_r       <= i_r + KEY_STEP;
      m_r       <= (m_r >= 3'd2) ? (m_r - 3'd2) : (m_r + 3'd5);
    end
  end

  // Counter word update for the selected word, carry ripples across cycles.
  assign ctr_sum = {1'b0, cs_r[cmd.idx]} + {1'b0, ctr_add(cmd.idx)} + {32'b0, carry_r};

  // Next state words from the g values.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if ((j % 2) == 0) begin
        xs_new[j] = gv_r[j] +
                    {gv_r[3'(j + 7)][15:0], gv_r[3'(j + 7)][31:16]} +
                    {gv_r[3'(j + 6)][15:0], gv_r[3'(j + 6)][31:16]};
      end else begin
        xs_new[j] = gv_r[j] +
                    {gv_r[3'(j + 7)][23:0], gv_r[3'(j + 7)][31:24]} +
                    gv_r[3'(j + 6)];
      end
    end
  end

  assign sq_in = xs_r[cmd.idx] + cs_r[cmd.idx];

  // Cipher state registers.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      for (int j = 0; j < 8; j++) begin
        if ((j % 2) == 0) begin
          xs_r[j] <= {kw_r[3'(j + 1)], kw_r[j]};
          cs_r[j] <= {kw_r[3'(j + 4)], kw_r[3'(j + 5)]};
        end else begin
          xs_r[j] <= {kw_r[3'(j + 5)], kw_r[3'(j + 4)]};
          cs_r[j] <= {kw_r[j], kw_r[3'(j + 1)]};
        end
      end
      carry_r <= 1'b0;
    end else if (cmd.ctr_step) begin
      cs_r[cmd.idx] <= ctr_sum[31:0];
      carry_r       <= ctr_sum[32];
    end else if (cmd.xs_upd) begin
      for (int j = 0; j < 8; j++) begin
        xs_r[j] <= xs_new[j];
      end
    end else if (cmd.reinit) begin
      for (int j = 0; j < 8; j++) begin
        cs_r[j] <= cs_r[j] ^ xs_r[3'(j + 4)];
      end
    end
    if (cmd.mul) begin
      prod_r <= {32'b0, sq_in} * {32'b0, sq_in};
    end
    if (cmd.gv) begin
      gv_r[cmd.idx] <= prod_r[63:32] ^ prod_r[31:0];
    end
  end

  // Output word selection for the current extraction byte.
  assign wn = cmd.ext_byte[3:1];

  always_comb begin
    if (!wn[0]) begin
      wword = xs_r[wn][15:0] ^ xs_r[3'(wn + 5)][31:16];
    end else begin
      wword = xs_r[3'(wn - 1)][31:16] ^ xs_r[3'(wn + 2)][15:0];
    end
    wbyte = cmd.ext_byte[0] ? wword[15:8] : wword[7:0];
  end

  // Keystream cache: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.ks_wr) begin
      ks_mem[wr_addr] <= wbyte;
    end
    if (cmd.rd) begin
      rd0_r <= ks_mem[addr0];
      rd2_r <= ks_mem[addr2];
    end
  end

  // Check nibble and decrypted status.
  assign match = sts.eligible && (rd2_r[7:4] == (chk_r[7:4] ^ CHK_XOR));
  assign dec   = (stat_r ^ rd0_r) & STATUS_MASK;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fv_r   <= match;
      so_r   <= match ? dec : stat_r;
      bits_r <= match ? dec[7:2] : 6'b0;
    end
  end

  assign out_flags_valid = fv_r;
  assign out_status_out  = so_r;
  assign out_loop_one    = bits_r[5];
  assign out_tamper      = bits_r[4];
  assign out_loop_two    = bits_r[3];
  assign out_alarm       = bits_r[2];
  assign out_low_batt    = bits_r[1];
  assign out_heartbeat   = bits_r[0];

endmodule

// ===== rtl/rksd_controller.sv =====
// Controller: state machine that sequences key schedule, cipher rounds,
// keystream extraction and the result handshake. Depends on rksd_pkg.
module rksd_controller import rksd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  rksd_sts_t sts,
  output rksd_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_KINIT  = 4'd3;
  localparam logic [3:0] S_KEY    = 4'd4;
  localparam logic [3:0] S_SETUP  = 4'd5;
  localparam logic [3:0] S_CTR    = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_GV     = 4'd8;
  localparam logic [3:0] S_XS     = 4'd9;
  localparam logic [3:0] S_REINIT = 4'd10;
  localparam logic [3:0] S_EXT    = 4'd11;
  localparam logic [3:0] S_MARK   = 4'd12;
  localparam logic [3:0] S_RD     = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  localparam logic [2:0] RND_LAST_SETUP = 3'd3;
  localparam logic [2:0] RND_LAST       = 3'd6;

  logic [3:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] rnd_r, rnd_nxt;
  logic [3:0] byte_r, byte_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 3'd0;
      rnd_r       <= 3'd0;
      byte_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rnd_r       <= rnd_nxt;
      byte_r      <= byte_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rnd_nxt      = rnd_r;
    byte_nxt     = byte_r;
    cmd          = '0;
    cmd.idx      = idx_r;
    cmd.ext_rnd  = rnd_r[1:0];
    cmd.ext_byte = byte_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_frame = 1'b1;
          state_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.eligible) begin
          state_nxt = S_FIN;
        end else if (sts.need_gen) begin
          state_nxt = S_KINIT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_KINIT: begin
        cmd.key_init = 1'b1;
        state_nxt    = S_KEY;
      end
      S_KEY: begin
        cmd.key_step = 1'b1;
        if (sts.key_last) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        rnd_nxt   = 3'd0;
        idx_nxt   = 3'd0;
        state_nxt = S_CTR;
      end
      S_CTR: begin
        cmd.ctr_step = 1'b1;
        idx_nxt      = idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_GV;
      end
      S_GV: begin
        cmd.gv  = 1'b1;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          state_nxt = S_XS;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_XS: begin
        cmd.xs_upd = 1'b1;
        byte_nxt   = 4'd0;
        if (rnd_r == RND_LAST_SETUP) begin
          state_nxt = S_REINIT;
        end else if (rnd_r > RND_LAST_SETUP) begin
          state_nxt = S_EXT;
        end else begin
          rnd_nxt   = rnd_r + 3'd1;
          state_nxt = S_CTR;
        end
      end
      S_REINIT: begin
        cmd.reinit = 1'b1;
        rnd_nxt    = rnd_r + 3'd1;
        state_nxt  = S_CTR;
      end
      S_EXT: begin
        cmd.ks_wr = 1'b1;
        byte_nxt  = byte_r + 4'd1;
        if (byte_r == 4'd15) begin
          if (rnd_r == RND_LAST) begin
            state_nxt = S_MARK;
          end else begin
            rnd_nxt   = rnd_r + 3'd1;
            state_nxt = S_CTR;
          end
        end
      end
      S_MARK: begin
        cmd.cache_mark = 1'b1;
        state_nxt      = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result word stays until the receiver takes it.
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

endmodule

// ===== rtl/rabbit_keystream_status_decrypt_unit.sv =====
// Top level of the status keystream decrypt unit.
// Instantiates rksd_controller and rksd_datapath; depends on rksd_pkg.
//
// One frame word in gives one result word out. When the subtype, seed or
// counter rules out decryption, a word passes the load, divide, decide and
// finish states; with the keystream for its counter's group of 12 cached,
// it adds a cache read. On a cache miss the key schedule runs one mixing
// step per cycle, and each of the seven cipher rounds uses one shared 32x32
// squarer and one counter adder over eight words; each of the last three
// rounds is followed by 16 single-byte writes into the keystream cache, 48
// in all. A finished result is held in an output register, so a new word
// is taken as soon as the sequence ends, even while the result waits. A
// seed write invalidates the cache and must be done while the unit is idle.
module rabbit_keystream_status_decrypt_unit import rksd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_subtype,
  input  logic [15:0] in_frame_counter,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_check_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_flags_valid,
  output logic [7:0]  out_status_out,
  output logic        out_loop_one,
  output logic        out_tamper,
  output logic        out_loop_two,
  output logic        out_alarm,
  output logic        out_low_batt,
  output logic        out_heartbeat
);

  rksd_cmd_t cmd;
  rksd_sts_t sts;

  // Sequencer.
  rksd_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cipher datapath and keystream cache.
  rksd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_frame_subtype (in_frame_subtype),
    .in_frame_counter (in_frame_counter),
    .in_status_byte   (in_status_byte),
    .in_check_byte    (in_check_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_flags_valid  (out_flags_valid),
    .out_status_out   (out_status_out),
    .out_loop_one     (out_loop_one),
    .out_tamper       (out_tamper),
    .out_loop_two     (out_loop_two),
    .out_alarm        (out_alarm),
    .out_low_batt     (out_low_batt),
    .out_heartbeat    (out_heartbeat)
  );

endmodule
